### hw/rtl/json_string_escaper_macros.svh
// Assertion helpers for the escaper. All checks are clocked on clk and
// are switched off while rst_n is low.
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("json_string_escaper: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("json_string_escaper: next-cycle check failed");

`endif

### hw/rtl/jse_pkg.sv
`default_nettype none
package jse_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_END   = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_LEAD  = 3'd1,
    ERR_BAD_CONT  = 3'd2,
    ERR_OVERLONG  = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_RANGE     = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_ESC2,
    CMD_U16,
    CMD_PAIR,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] val0;
    logic [15:0] val1;
    err_t        err;
  } cmd_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [QCntW-1:0] count;
  } qstat_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SUR_LO   = 21'h00D800;
  localparam logic [20:0] CP_SUR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_PLANE1   = 21'h010000;
  localparam logic [20:0] CP_BMP_MAX  = 21'h00FFFF;
  localparam logic [5:0]  SUR_HI_PFX  = 6'b110110;
  localparam logic [5:0]  SUR_LO_PFX  = 6'b110111;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/json_string_escaper.sv
// JSON string escaper. Each input transfer is a start marker, a string
// byte or an end marker (in_tuser); each output transfer is one byte of
// the quoted, escaped string, or an error result with out_tuser low and
// the code in out_tdata. out_tlast closes the results of one input item.
// The front end accepts one item per cycle while the queue is not full
// and decodes it into at most one command; a four-entry command queue
// separates it from the back end, which writes one output byte per
// cycle, unless out_tready stalls or the queue is empty, from a
// registered output stage. A short escape gives two bytes, a \uXXXX
// escape six and a surrogate pair twelve; the output port sets the
// sustained rate. An item passes through its queue entry and then the
// output register. The user must write ascii_mode through the cfg port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "json_string_escaper_macros.svh"
module json_string_escaper import jse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,   // ascii_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte [7:0], error_code [10:8], zero above
  output logic        out_tuser,  // byte_valid
  output logic        out_tlast   // last_of_run
);

  qstat_t q_stat;
  logic   push;
  logic   pop;
  cmd_t   push_cmd;
  cmd_t   head;

  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  jse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `JSE_ASSERT_NOW(a_err_is_single, out_tvalid && !out_tuser, out_tlast && out_tdata[7:0] == 8'h00)
  `JSE_ASSERT_NOW(a_char_no_code, out_tvalid && out_tuser, out_tdata[10:8] == ERR_NONE)
  `JSE_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= QCntW'(QDepth) && (in_tready == !q_stat.full))
  `JSE_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty)
  `JSE_ASSERT_NEXT(a_push_fills, push && !pop, !q_stat.empty)

endmodule
`default_nettype wire

### hw/rtl/jse_front.sv
`default_nettype none
module jse_front import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [1:0] in_tuser,
  input  qstat_t     q_stat,
  output logic       push,
  output cmd_t       push_cmd
);

  logic        ascii_mode_r;
  logic [1:0]  bytes_left_r, bytes_left_nxt;
  logic [1:0]  seq_len_r, seq_len_nxt;
  logic [20:0] partial_r, partial_nxt;
  logic        err_seen_r, err_seen_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [20:0] cp_n;
  logic [20:0] lim;
  logic [20:0] s;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign cp_n      = {partial_r[14:0], b[5:0]};
  assign s         = cp_n - CP_PLANE1;

  always_comb begin
    unique case (seq_len_r)
      2'd1:    lim = 21'h000080;
      2'd2:    lim = 21'h000800;
      default: lim = 21'h010000;
    endcase
  end

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    seq_len_nxt    = seq_len_r;
    partial_nxt    = partial_r;
    err_seen_nxt   = err_seen_r;
    push           = 1'b0;
    push_cmd       = '{kind: CMD_CHAR, val0: 16'h0000, val1: 16'h0000, err: ERR_NONE};
    if (accept) begin
      unique case (in_tuser)
        REQ_START: begin
          bytes_left_nxt = 2'd0;
          seq_len_nxt    = 2'd0;
          partial_nxt    = '0;
          err_seen_nxt   = 1'b0;
          push           = 1'b1;
          push_cmd.val0  = {8'h00, CH_QUOTE};
        end
        REQ_DATA: begin
          if (!err_seen_r) begin
            if (bytes_left_r != 2'd0) begin
              if (b[7:6] != 2'b10) begin
                push           = 1'b1;
                push_cmd.kind  = CMD_ERR;
                push_cmd.err   = ERR_BAD_CONT;
                err_seen_nxt   = 1'b1;
                bytes_left_nxt = 2'd0;
                seq_len_nxt    = 2'd0;
                partial_nxt    = '0;
              end else if (bytes_left_r != 2'd1) begin
                partial_nxt    = cp_n;
                bytes_left_nxt = bytes_left_r - 2'd1;
              end else begin
                bytes_left_nxt = 2'd0;
                seq_len_nxt    = 2'd0;
                partial_nxt    = '0;
                push           = 1'b1;
                if (cp_n < lim) begin
                  push_cmd.kind = CMD_ERR;
                  push_cmd.err  = ERR_OVERLONG;
                  err_seen_nxt  = 1'b1;
                end else if (cp_n > CP_MAX || (cp_n >= CP_SUR_LO && cp_n <= CP_SUR_HI)) begin
                  push_cmd.kind = CMD_ERR;
                  push_cmd.err  = ERR_RANGE;
                  err_seen_nxt  = 1'b1;
                end else if (cp_n <= CP_BMP_MAX) begin
                  push_cmd.kind = CMD_U16;
                  push_cmd.val0 = cp_n[15:0];
                end else begin
                  push_cmd.kind = CMD_PAIR;
                  push_cmd.val0 = {SUR_HI_PFX, s[19:10]};
                  push_cmd.val1 = {SUR_LO_PFX, s[9:0]};
                end
              end
            end else if (b < 8'h20) begin
              push = 1'b1;
              unique case (b)
                8'h08: begin push_cmd.kind = CMD_ESC2; push_cmd.val0 = 16'h0062; end
                8'h09: begin push_cmd.kind = CMD_ESC2; push_cmd.val0 = 16'h0074; end
                8'h0A: begin push_cmd.kind = CMD_ESC2; push_cmd.val0 = 16'h006E; end
                8'h0C: begin push_cmd.kind = CMD_ESC2; push_cmd.val0 = 16'h0066; end
                8'h0D: begin push_cmd.kind = CMD_ESC2; push_cmd.val0 = 16'h0072; end
                default: begin
                  push_cmd.kind = CMD_U16;
                  push_cmd.val0 = {8'h00, b};
                end
              endcase
            end else if (b == CH_QUOTE || b == CH_BSL) begin
              push          = 1'b1;
              push_cmd.kind = CMD_ESC2;
              push_cmd.val0 = {8'h00, b};
            end else if (ascii_mode_r && b[7]) begin
              if (b < 8'hC0 || b >= 8'hF8) begin
                push          = 1'b1;
                push_cmd.kind = CMD_ERR;
                push_cmd.err  = ERR_BAD_LEAD;
                err_seen_nxt  = 1'b1;
              end else if (b < 8'hE0) begin
                seq_len_nxt    = 2'd1;
                bytes_left_nxt = 2'd1;
                partial_nxt    = {16'h0000, b[4:0]};
              end else if (b < 8'hF0) begin
                seq_len_nxt    = 2'd2;
                bytes_left_nxt = 2'd2;
                partial_nxt    = {17'h00000, b[3:0]};
              end else begin
                seq_len_nxt    = 2'd3;
                bytes_left_nxt = 2'd3;
                partial_nxt    = {18'h00000, b[2:0]};
              end
            end else begin
              push          = 1'b1;
              push_cmd.val0 = {8'h00, b};
            end
          end
        end
        REQ_END: begin
          bytes_left_nxt = 2'd0;
          seq_len_nxt    = 2'd0;
          partial_nxt    = '0;
          err_seen_nxt   = 1'b0;
          if (!err_seen_r) begin
            push = 1'b1;
            if (bytes_left_r != 2'd0) begin
              push_cmd.kind = CMD_ERR;
              push_cmd.err  = ERR_TRUNCATED;
            end else begin
              push_cmd.val0 = {8'h00, CH_QUOTE};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascii_mode_r <= 1'b0;
      bytes_left_r <= 2'd0;
      seq_len_r    <= 2'd0;
      partial_r    <= '0;
      err_seen_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ascii_mode_r <= cfg_data;
      end
      bytes_left_r <= bytes_left_nxt;
      seq_len_r    <= seq_len_nxt;
      partial_r    <= partial_nxt;
      err_seen_r   <= err_seen_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/jse_queue.sv
`default_nettype none
module jse_queue import jse_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   head,
  output qstat_t q_stat
);

  cmd_t             mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QCntW-1:0] count_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCntW'(QDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= QPtrW'((32'(wr_ptr_r) + 1) % QDepth);
      end
      if (pop) begin
        rd_ptr_r <= QPtrW'((32'(rd_ptr_r) + 1) % QDepth);
      end
      if (push && !pop) begin
        count_r <= count_r + QCntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/jse_back.sv
`default_nettype none
module jse_back import jse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        head,
  input  qstat_t      q_stat,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic [3:0]  idx_r, idx_nxt;
  logic        tvalid_r, tvalid_nxt;
  logic [7:0]  byte_r;
  logic [2:0]  err_r;
  logic        bvalid_r;
  logic        last_r;

  logic        emit;
  logic [3:0]  last_idx;
  logic        is_last;
  logic        second;
  logic [15:0] seg;
  logic [2:0]  pos;
  logic [7:0]  ch;

  assign emit    = !q_stat.empty && (!tvalid_r || out_tready);
  assign is_last = (idx_r == last_idx);
  assign pop     = emit && is_last;
  assign second  = (idx_r >= 4'd6);
  assign seg     = second ? head.val1 : head.val0;
  assign pos     = second ? 3'(idx_r - 4'd6) : idx_r[2:0];

  always_comb begin
    unique case (head.kind)
      CMD_ESC2: last_idx = 4'd1;
      CMD_U16:  last_idx = 4'd5;
      CMD_PAIR: last_idx = 4'd11;
      default:  last_idx = 4'd0;
    endcase
  end

  always_comb begin
    ch = 8'h00;
    unique case (head.kind)
      CMD_CHAR: ch = head.val0[7:0];
      CMD_ESC2: ch = (idx_r == 4'd0) ? CH_BSL : head.val0[7:0];
      CMD_U16, CMD_PAIR: begin
        unique case (pos)
          3'd0:    ch = CH_BSL;
          3'd1:    ch = CH_U;
          3'd2:    ch = hex_char(seg[15:12]);
          3'd3:    ch = hex_char(seg[11:8]);
          3'd4:    ch = hex_char(seg[7:4]);
          default: ch = hex_char(seg[3:0]);
        endcase
      end
      default: ch = 8'h00;
    endcase
  end

  always_comb begin
    idx_nxt    = idx_r;
    tvalid_nxt = tvalid_r;
    if (out_tready) begin
      tvalid_nxt = 1'b0;
    end
    if (emit) begin
      tvalid_nxt = 1'b1;
      idx_nxt    = is_last ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= 4'd0;
      tvalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      tvalid_r <= tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r   <= ch;
      err_r    <= (head.kind == CMD_ERR) ? head.err : ERR_NONE;
      bvalid_r <= (head.kind != CMD_ERR);
      last_r   <= is_last;
    end
  end

  assign out_tvalid = tvalid_r;
  assign out_tdata  = {5'b00000, err_r, byte_r};
  assign out_tuser  = bvalid_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire
